[hdl/psu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the particle swarm update unit
// Field widths, arithmetic constants, register indexes and the stored particle
// record.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int POS_W   = 5;
  localparam int VEL_W   = 9;
  localparam int CFG_W   = 10;
  localparam int RAND_W  = 7;
  localparam int INDEX_W = 4;
  localparam int ACC_W   = 28;
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 15;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [POS_W-1:0] POS_MAX   = 5'd31;
  localparam logic [7:0]       VEL_LIMIT = 8'd255;

  // Velocity is (sum / 25600), done as (|sum| >> 10) / 25.
  localparam logic [MUL_B_W-1:0] HUNDRED   = 15'd100;
  localparam logic [MUL_B_W-1:0] RECIP_25  = 15'd5243;  // 2^17 / 25, rounded up
  localparam int                 RECIP_SH  = 17;
  localparam logic [ACC_W-1:0]   SAT_LEVEL = 28'd6528000;  // 255 * 25600

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic [1:0] REG_INERTIA = 2'd0;
  localparam logic [1:0] REG_OWN     = 2'd1;
  localparam logic [1:0] REG_SWARM   = 2'd2;

  localparam logic [CFG_W-1:0] INERTIA_RESET = 10'd128;
  localparam logic [CFG_W-1:0] OWN_RESET     = 10'd384;
  localparam logic [CFG_W-1:0] SWARM_RESET   = 10'd384;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VEL_W-1:0] vel;
    logic [POS_W-1:0]        pbest;
  } particle_t;

endpackage

[hdl/particle_swarm_update_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_swarm_update_unit: integer particle swarm step engine
// Holds a swarm of particles and the global best, and performs load and
// velocity/position update requests one at a time on a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request. mode 0 loads a
//   particle, mode 1 updates it with the two random hundredths. Every request
//   returns exactly one result on the output channel (out_valid/out_ready).
//   The user must write configuration registers (inertia, own pull, swarm pull)
//   via cfg_write/cfg_index/cfg_data while no request is in flight (unchecked).
// Timing:
//   A load goes from acceptance straight to write-back (S_FIN); an update first
//   steps S_READ to S_DIV, running six products and one reciprocal division
//   product through a single 18x15 multiplier, one per cycle, plus the particle
//   memory read and a final write-back. in_ready returns as the result register
//   is loaded, so each request finishes before the next one is accepted.
// Reset and stalls:
//   Reset restores the register defaults and clears the global best; particle
//   records hold nothing until loaded. If the receiver stalls, a finished
//   result waits in the output register while the next request is accepted
//   and computed; the engine then holds in its last step until the output
//   register frees up.
// ----------------------------------------------------------------------------
module particle_swarm_update_unit #(
  parameter int PARTICLES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [psu_pkg::CFG_W-1:0]      cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [psu_pkg::INDEX_W-1:0]    particle_index,
  input  logic [psu_pkg::POS_W-1:0]      start_position,
  input  logic signed [2:0]              start_velocity,
  input  logic [psu_pkg::RAND_W-1:0]     rand_own,
  input  logic [psu_pkg::RAND_W-1:0]     rand_swarm,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [psu_pkg::POS_W-1:0]      new_position,
  output logic signed [psu_pkg::VEL_W-1:0] new_velocity,
  output logic [psu_pkg::POS_W-1:0]      personal_best,
  output logic [psu_pkg::POS_W-1:0]      swarm_best,
  output logic [9:0]                     swarm_best_value
);

  import psu_pkg::*;

  localparam int IDX_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;  // memory read, w * 100
  localparam logic [3:0] S_T0   = 4'd2;  // inertia term
  localparam logic [3:0] S_K1   = 4'd3;  // a1 * r1
  localparam logic [3:0] S_T1   = 4'd4;  // personal term
  localparam logic [3:0] S_K2   = 4'd5;  // a2 * r2
  localparam logic [3:0] S_T2   = 4'd6;  // swarm term
  localparam logic [3:0] S_ABS  = 4'd7;  // sum, magnitude, saturation check
  localparam logic [3:0] S_DIV  = 4'd8;  // divide by 25 via reciprocal
  localparam logic [3:0] S_FIN  = 4'd9;  // write back and load result

  // Index wrap by restoring subtraction of the particle count.
  function automatic logic [IDX_W-1:0] wrap_index(input logic [INDEX_W-1:0] raw);
    logic [10:0] rem;
    rem = {7'b0, raw};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= 11'(PARTICLES << k)) begin
        rem = rem - 11'(PARTICLES << k);
      end
    end
    return rem[IDX_W-1:0];
  endfunction

  logic [3:0]                state;
  logic [CFG_W-1:0]          inertia;
  logic [CFG_W-1:0]          own_pull;
  logic [CFG_W-1:0]          swarm_pull;
  logic [POS_W-1:0]          gbest;

  logic                      mode_r;
  logic [IDX_W-1:0]          idx_r;
  logic [POS_W-1:0]          start_pos_r;
  logic signed [2:0]         start_vel_r;
  logic [RAND_W-1:0]         r1_r;
  logic [RAND_W-1:0]         r2_r;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          mag;
  logic                      neg;
  logic                      sat;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   sum;
  logic [ACC_W-1:0]          sum_mag;

  particle_t                 rd_rec;
  particle_t                 wr_rec;
  logic                      in_fire;
  logic                      fin_fire;

  logic signed [5:0]         own_diff;
  logic signed [5:0]         swarm_diff;
  logic [7:0]                quot;
  logic signed [VEL_W-1:0]   vel_upd;
  logic signed [9:0]         pos_sum;
  logic [POS_W-1:0]          pos_upd;
  logic [POS_W-1:0]          pos_load;
  logic [POS_W-1:0]          pbest_next;
  logic [POS_W-1:0]          gbest_next;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ready);

  psu_ram #(
    .WIDTH ($bits(particle_t)),
    .DEPTH (PARTICLES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (fin_fire),
    .waddr(idx_r),
    .wdata(wr_rec),
    .re   (in_fire),
    .raddr(wrap_index(particle_index)),
    .rdata(rd_rec)
  );

  // The memory output holds the record read at acceptance for the whole request.
  assign own_diff   = $signed({1'b0, rd_rec.pbest}) - $signed({1'b0, rd_rec.pos});
  assign swarm_diff = $signed({1'b0, gbest}) - $signed({1'b0, rd_rec.pos});

  always_comb begin
    mul_a = {8'b0, inertia};
    mul_b = HUNDRED;
    case (state)
      S_READ: begin
        mul_a = {8'b0, inertia};
        mul_b = HUNDRED;
      end
      S_T0: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-VEL_W){rd_rec.vel[VEL_W-1]}}, rd_rec.vel};
      end
      S_K1: begin
        mul_a = {8'b0, own_pull};
        mul_b = {8'b0, r1_r};
      end
      S_T1: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-6){own_diff[5]}}, own_diff};
      end
      S_K2: begin
        mul_a = {8'b0, swarm_pull};
        mul_b = {8'b0, r2_r};
      end
      S_T2: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-6){swarm_diff[5]}}, swarm_diff};
      end
      S_DIV: begin
        mul_a = {1'b0, mag[26:10]};
        mul_b = RECIP_25;
      end
      default: begin
        mul_a = {8'b0, inertia};
        mul_b = HUNDRED;
      end
    endcase
  end

  assign sum     = acc + $signed(prod[ACC_W-1:0]);
  assign sum_mag = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);

  // Final velocity, position and bests.
  assign quot     = sat ? VEL_LIMIT : prod[RECIP_SH+7:RECIP_SH];
  assign vel_upd  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign pos_sum  = $signed({5'b0, rd_rec.pos}) + 10'(vel_upd);
  assign pos_load = (start_pos_r > POS_MAX) ? POS_MAX : start_pos_r;

  always_comb begin
    if (pos_sum < 0) begin
      pos_upd = '0;
    end else if (pos_sum > $signed({5'b0, POS_MAX})) begin
      pos_upd = POS_MAX;
    end else begin
      pos_upd = pos_sum[POS_W-1:0];
    end

    if (mode_r == MODE_LOAD) begin
      wr_rec.pos   = pos_load;
      wr_rec.vel   = VEL_W'(start_vel_r);
      pbest_next   = pos_load;
    end else begin
      wr_rec.pos   = pos_upd;
      wr_rec.vel   = vel_upd;
      pbest_next   = (pos_upd > rd_rec.pbest) ? pos_upd : rd_rec.pbest;
    end
    wr_rec.pbest = pbest_next;
    gbest_next   = (pbest_next > gbest) ? pbest_next : gbest;
  end

  // Control and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      inertia    <= INERTIA_RESET;
      own_pull   <= OWN_RESET;
      swarm_pull <= SWARM_RESET;
      gbest      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_INERTIA: inertia    <= cfg_data;
          REG_OWN:     own_pull   <= cfg_data;
          REG_SWARM:   swarm_pull <= cfg_data;
          default: ;
        endcase
      end

      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= (mode == MODE_LOAD) ? S_FIN : S_READ;
          end
        end
        S_READ: state <= S_T0;
        S_T0:   state <= S_K1;
        S_K1:   state <= S_T1;
        S_T1:   state <= S_K2;
        S_K2:   state <= S_T2;
        S_T2:   state <= S_ABS;
        S_ABS:  state <= S_DIV;
        S_DIV:  state <= S_FIN;
        S_FIN: begin
          if (fin_fire) begin
            gbest <= gbest_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r      <= mode;
      idx_r       <= wrap_index(particle_index);
      start_pos_r <= start_position;
      start_vel_r <= start_velocity;
      r1_r        <= rand_own;
      r2_r        <= rand_swarm;
    end

    case (state)
      S_READ, S_T0, S_K1, S_T1, S_K2, S_T2, S_DIV: begin
        prod <= mul_a * mul_b;
      end
      default: ;
    endcase

    if (state == S_K1) begin
      acc <= $signed(prod[ACC_W-1:0]);
    end else if (state == S_K2) begin
      acc <= sum;
    end

    if (state == S_ABS) begin
      neg <= sum[ACC_W-1];
      mag <= sum_mag;
      sat <= (sum_mag >= SAT_LEVEL);
    end

    if (fin_fire) begin
      new_position     <= wr_rec.pos;
      new_velocity     <= wr_rec.vel;
      personal_best    <= wr_rec.pbest;
      swarm_best       <= gbest_next;
      swarm_best_value <= 10'({5'b0, gbest_next} * {5'b0, gbest_next});
    end
  end

  // The global best never falls outside of reset.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> gbest >= $past(gbest))
    else $error("global best decreased");

  // A result's personal best is at least its position and at most the swarm best.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (personal_best >= new_position) && (personal_best <= swarm_best))
    else $error("result bests inconsistent");

  // The fitness output is the square of the reported swarm best.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> swarm_best_value == 10'({5'b0, swarm_best} * {5'b0, swarm_best}))
    else $error("swarm best value mismatch");

endmodule

[hdl/psu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
